FILE: sv/ccp_pkg.sv
// Package for the cache-control header parser: widths, keyword tables, result type.
package ccp_pkg;

  localparam int AGE_BITS = 32;
  localparam int WIDE_BITS = AGE_BITS + 4;
  localparam int OUT_AGE_BITS = 32;
  localparam int KW_COUNT = 5;
  localparam int KW_CHARS = 8;
  localparam int POS_BITS = 4;

  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // keyword order: no-store, no-cache, private, public, max-age= prefix
  localparam int KW_NO_STORE = 0;
  localparam int KW_NO_CACHE = 1;
  localparam int KW_PRIVATE = 2;
  localparam int KW_PUBLIC = 3;
  localparam int KW_MAX_AGE = 4;

  localparam logic [POS_BITS-1:0] KW_LEN [KW_COUNT] = '{
    4'd8, 4'd8, 4'd7, 4'd6, 4'd8
  };

  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_CHARS] = '{
    '{"n", "o", "-", "s", "t", "o", "r", "e"},
    '{"n", "o", "-", "c", "a", "c", "h", "e"},
    '{"p", "r", "i", "v", "a", "t", "e", 8'h00},
    '{"p", "u", "b", "l", "i", "c", 8'h00, 8'h00},
    '{"m", "a", "x", "-", "a", "g", "e", "="}
  };

  localparam logic [7:0] CHAR_COMMA = ",";
  localparam logic [7:0] CHAR_SPACE = " ";
  localparam logic [7:0] CHAR_0 = "0";
  localparam logic [7:0] CHAR_9 = "9";
  localparam logic [7:0] CHAR_UPPER_A = "A";
  localparam logic [7:0] CHAR_UPPER_Z = "Z";
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  // bit 0 no-cache, bit 1 private, bit 2 public
  typedef struct packed {
    logic [2:0] seen;
    logic [AGE_BITS-1:0] age;
  } summary_t;

endpackage

FILE: sv/cache_control_header_parser_top.sv
// Cache-control header parser: one header byte per word in, one summary word per header out.
//
// Input channel s_axis: one header character per word in tdata[7:0]; tlast marks the final
// character of the header value. Output channel m_axis: one summary word per header,
// sent for the word that carries tlast.
// Each accepted byte updates the token state in the cycle it is accepted; the summary sits
// in the output register and is valid in the cycle after the last byte is accepted.
// Throughput is one byte per cycle: s_axis_tready is high whenever the output register is
// empty or is being read in the same cycle.
// When the receiver stalls with a summary pending, s_axis_tready drops and no byte is
// taken until that summary is read; bytes then flow again in the same cycle.
// The age multiply-by-ten and saturation compare form the longest path.
// Reset (rst, synchronous, active high) empties the output register and returns the
// token state, flags and age to their defaults; after each header the same defaults return.
module cache_control_header_parser_top
  import ccp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] header_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // [0] no_store (always 1), [1] no_cache, [2] private_flag,
                                      // [3] public_flag, [35:4] max_age, [39:36] zero
);

  logic [POS_BITS-1:0] token_position;
  logic [KW_COUNT-1:0] keyword_alive;
  logic                in_token;
  logic                digits_stopped;
  logic [AGE_BITS-1:0] age_accumulator;
  logic [AGE_BITS-1:0] age_value;
  logic [2:0]          seen_flags;

  logic [POS_BITS-1:0] token_position_next;
  logic [KW_COUNT-1:0] keyword_alive_next;
  logic                in_token_next;
  logic                digits_stopped_next;
  logic [AGE_BITS-1:0] age_accumulator_next;
  summary_t            summary_next;
  summary_t            summary_last;

  logic [3:0]          out_flags;
  logic [OUT_AGE_BITS-1:0] out_age;

  logic                accept;
  logic                out_load;
  logic [7:0]          lower;
  logic                is_sep;
  logic                is_digit;
  logic [3:0]          digit;
  logic [KW_COUNT-1:0] alive_take;
  logic [WIDE_BITS-1:0] acc_wide;
  summary_t            summary_cur;

  function automatic summary_t end_token(
    input logic                in_tok,
    input logic [KW_COUNT-1:0] alive,
    input logic [POS_BITS-1:0] pos,
    input logic [AGE_BITS-1:0] acc,
    input summary_t            prev
  );
    summary_t s;
    s = prev;
    if (in_tok) begin
      if (alive[KW_NO_CACHE] && pos == KW_LEN[KW_NO_CACHE]) s.seen[0] = 1'b1;
      if (alive[KW_PRIVATE] && pos == KW_LEN[KW_PRIVATE]) s.seen[1] = 1'b1;
      if (alive[KW_PUBLIC] && pos == KW_LEN[KW_PUBLIC]) s.seen[2] = 1'b1;
      if (alive[KW_MAX_AGE] && pos >= KW_LEN[KW_MAX_AGE]) s.age = acc;
    end
    return s;
  endfunction

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_load = accept && s_axis_tlast;

  always_comb begin
    lower = s_axis_tdata;
    if (s_axis_tdata >= CHAR_UPPER_A && s_axis_tdata <= CHAR_UPPER_Z) begin
      lower = s_axis_tdata + CASE_OFFSET;
    end
    is_sep = (s_axis_tdata == CHAR_COMMA) || (s_axis_tdata == CHAR_SPACE);
    is_digit = (lower >= CHAR_0) && (lower <= CHAR_9);
    digit = 4'(lower - CHAR_0);

    for (int k = 0; k < KW_COUNT; k++) begin
      alive_take[k] = keyword_alive[k];
      if (token_position < KW_LEN[k]) begin
        if (lower != KW_TEXT[k][token_position[2:0]]) alive_take[k] = 1'b0;
      end else if (k != KW_MAX_AGE) begin
        alive_take[k] = 1'b0;
      end
    end

    acc_wide = (WIDE_BITS'(age_accumulator) << 3) + (WIDE_BITS'(age_accumulator) << 1)
             + WIDE_BITS'(digit);

    summary_cur.seen = seen_flags;
    summary_cur.age = age_value;

    if (is_sep) begin
      summary_next = end_token(in_token, keyword_alive, token_position, age_accumulator,
                               summary_cur);
      token_position_next = '0;
      keyword_alive_next = '1;
      in_token_next = 1'b0;
      digits_stopped_next = 1'b0;
      age_accumulator_next = '0;
    end else begin
      summary_next = summary_cur;
      keyword_alive_next = alive_take;
      in_token_next = 1'b1;
      digits_stopped_next = digits_stopped;
      age_accumulator_next = age_accumulator;
      if (alive_take[KW_MAX_AGE] && token_position >= KW_LEN[KW_MAX_AGE]
          && !digits_stopped) begin
        if (is_digit) begin
          if (acc_wide > WIDE_BITS'(AGE_MAX)) age_accumulator_next = AGE_MAX;
          else age_accumulator_next = acc_wide[AGE_BITS-1:0];
        end else begin
          digits_stopped_next = 1'b1;
        end
      end
      token_position_next = token_position;
      if (token_position != POS_MAX) token_position_next = token_position + 1'b1;
    end

    summary_last = end_token(in_token_next, keyword_alive_next, token_position_next,
                             age_accumulator_next, summary_next);
  end

  always_ff @(posedge clk) begin
    if (rst || out_load) begin
      token_position <= '0;
      keyword_alive <= '1;
      in_token <= 1'b0;
      digits_stopped <= 1'b0;
      age_accumulator <= '0;
      age_value <= '0;
      seen_flags <= '0;
    end else if (accept) begin
      token_position <= token_position_next;
      keyword_alive <= keyword_alive_next;
      in_token <= in_token_next;
      digits_stopped <= digits_stopped_next;
      age_accumulator <= age_accumulator_next;
      age_value <= summary_next.age;
      seen_flags <= summary_next.seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_flags <= {summary_last.seen, 1'b1};
      out_age <= OUT_AGE_BITS'(summary_last.age);
    end
  end

  assign m_axis_tdata = {4'b0000, out_age, out_flags};

endmodule
